// ===== src/crt_next_coincidence_top_macros.svh =====
// Assertion macros shared by the next-coincidence block.
`ifndef CRT_NEXT_COINCIDENCE_TOP_MACROS_SVH
`define CRT_NEXT_COINCIDENCE_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/crt_nc_pkg.sv =====
// Shared types and constants of the next-coincidence block.
package crt_nc_pkg;

  localparam int MODULUS_BITS_DEF = 10;
  localparam int RESIDUE_W        = 10;
  localparam int DAY_W            = 30;
  localparam int DAYS_W           = 32;
  localparam int CFG_DATA_W       = 32;
  localparam int CFG_ADDR_W       = 4;

  localparam int MOD_FIRST_RST  = 23;
  localparam int MOD_SECOND_RST = 28;
  localparam int MOD_THIRD_RST  = 33;

  localparam logic [1:0] REG_MOD_FIRST  = 2'd0;
  localparam logic [1:0] REG_MOD_SECOND = 2'd1;
  localparam logic [1:0] REG_MOD_THIRD  = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_EU_INIT,
    ST_EU_CHK,
    ST_EU_DIV,
    ST_EU_MUL,
    ST_EU_UPD,
    ST_K_MUL,
    ST_K_DIV1,
    ST_K_DIV2,
    ST_K_DIV3,
    ST_L_DIV,
    ST_L_MUL,
    ST_R_MUL,
    ST_R_DIV1,
    ST_R_DIV2,
    ST_R_FIX,
    ST_FIN1,
    ST_FIN2,
    ST_OUT
  } crt_state_e;

endpackage

// ===== src/crt_nc_item_if.sv =====
// Input item channel: three residues and a reference day.
interface crt_nc_item_if import crt_nc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [RESIDUE_W-1:0] residue_first;
  logic [RESIDUE_W-1:0] residue_second;
  logic [RESIDUE_W-1:0] residue_third;
  logic [DAY_W-1:0]     reference_day;

  modport source (output valid, residue_first, residue_second, residue_third,
                  reference_day, input ready);
  modport sink (input valid, residue_first, residue_second, residue_third,
                reference_day, output ready);
endinterface

// ===== src/crt_nc_result_if.sv =====
// Result channel: days until the next coincidence.
interface crt_nc_result_if import crt_nc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DAYS_W-1:0] days_until;

  modport source (output valid, days_until, input ready);
  modport sink (input valid, days_until, output ready);
endinterface

// ===== src/crt_nc_div.sv =====
// Shared restoring divider, one quotient bit per cycle, truncating toward zero.
module crt_nc_div import crt_nc_pkg::*; #(
  parameter int W = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [W-1:0] dividend_i,
  input  logic        [W-1:0] divisor_i,
  output logic                done_o,
  output logic signed [W-1:0] quo_o,
  output logic signed [W-1:0] rem_o
);

  localparam int CW = $clog2(W + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic          neg_q;
  logic [W:0]    acc_q;
  logic [W-1:0]  sh_q;
  logic [W-1:0]  dvs_q;
  logic [W:0]    trial;
  logic          fits;

  assign trial = {acc_q[W-1:0], sh_q[W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Work on the magnitude; the sign goes back on at the output.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[W-1];
      sh_q  <= dividend_i[W-1] ? W'(-dividend_i) : W'(dividend_i);
      acc_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      acc_q <= fits ? trial - {1'b0, dvs_q} : trial;
      sh_q  <= {sh_q[W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed(sh_q) : $signed(sh_q);
  assign rem_o  = neg_q ? -$signed(acc_q[W-1:0]) : $signed(acc_q[W-1:0]);

endmodule

// ===== src/crt_next_coincidence_top.sv =====
// The shared divider is AW bits wide and serves every divide of both merges in turn, where
// AW = max(3*MODULUS_BITS, MODULUS_BITS + 10) + 2 (32 at the default width).
// One item at a time: a new item is taken only after the result of the last has transferred.
// Ready is high only while idle; the result waits in an output register until its transfer.
// Reset: asynchronous, active low; moduli return to 23, 28 and 33, sequencer to idle.
module crt_next_coincidence_top import crt_nc_pkg::*; #(
  parameter int MODULUS_BITS = MODULUS_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  crt_nc_item_if.sink           item_i,
  crt_nc_result_if.source       result_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

`include "crt_next_coincidence_top_macros.svh"

  localparam int B  = MODULUS_BITS;
  // Widest signed intermediate: c1 * (r2 - cur_r), cur_m * k, lcm plus sign headroom.
  localparam int AW = ((3 * B > B + 10) ? 3 * B : B + 10) + 2;
  // Bezout coefficients, k and a modulus fit this narrow operand.
  localparam int SW = B + 2;
  localparam int FW = ((AW > DAYS_W) ? AW : DAYS_W) + 1;

  // ---------------- configuration registers ----------------
  logic [B-1:0] mod_first_q, mod_second_q, mod_third_q;
  logic [1:0]   cfg_idx;
  logic         cfg_wr;

  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_first_q  <= B'(MOD_FIRST_RST);
      mod_second_q <= B'(MOD_SECOND_RST);
      mod_third_q  <= B'(MOD_THIRD_RST);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MOD_FIRST:  mod_first_q  <= pwdata[B-1:0];
        REG_MOD_SECOND: mod_second_q <= pwdata[B-1:0];
        REG_MOD_THIRD:  mod_third_q  <= pwdata[B-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MOD_FIRST:  prdata = CFG_DATA_W'(mod_first_q);
      REG_MOD_SECOND: prdata = CFG_DATA_W'(mod_second_q);
      REG_MOD_THIRD:  prdata = CFG_DATA_W'(mod_third_q);
      default:        prdata = '0;
    endcase
  end

  // A zero modulus acts as modulus 1.
  logic [B-1:0] eff_first, eff_second, eff_third;
  assign eff_first  = (mod_first_q  == '0) ? B'(1) : mod_first_q;
  assign eff_second = (mod_second_q == '0) ? B'(1) : mod_second_q;
  assign eff_third  = (mod_third_q  == '0) ? B'(1) : mod_third_q;

  // ---------------- sequencer ----------------
  crt_state_e state_q, state_d;
  logic       stage_q;

  // ---------------- datapath registers ----------------
  logic signed [AW-1:0] r_cur_q;   // merged residue so far
  logic signed [AW-1:0] m_cur_q;   // merged modulus so far
  logic [B-1:0]         mod2_q;    // modulus being merged in
  logic [RESIDUE_W-1:0] res2_q;    // residue being merged in
  logic [B-1:0]         mod3_q;
  logic [RESIDUE_W-1:0] res3_q;
  logic [DAY_W-1:0]     day_q;
  logic signed [AW-1:0] old_r_q, r_q;
  logic signed [SW-1:0] old_s_q, s_q;
  logic signed [AW-1:0] quo_q, rem_q;
  logic signed [AW-1:0] prod_q;
  logic signed [AW-1:0] t1_q, n_q;
  logic signed [SW-1:0] k_q;
  logic signed [AW-1:0] lcm_q;
  logic signed [AW-1:0] x_q;
  logic [DAYS_W-1:0]    out_q;

  // ---------------- shared units ----------------
  logic                 div_op, div_start, div_done, div_pend_q;
  logic signed [AW-1:0] div_a;
  logic        [AW-1:0] div_b;
  logic signed [AW-1:0] div_quo, div_rem;
  logic signed [AW-1:0] mul_big;
  logic signed [SW-1:0] mul_small;
  logic signed [AW+SW-1:0] mul_p;

  assign div_start = div_op && !div_pend_q;
  assign mul_p     = mul_big * mul_small;

  crt_nc_div #(.W(AW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_pend_q <= 1'b0;
    end else if (div_start) begin
      div_pend_q <= 1'b1;
    end else if (div_done) begin
      div_pend_q <= 1'b0;
    end
  end

  logic item_xfer, res_xfer;
  assign item_xfer = item_i.valid && item_i.ready;
  assign res_xfer  = result_o.valid && result_o.ready;

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (item_i.valid) state_d = ST_EU_INIT;
      ST_EU_INIT: state_d = ST_EU_CHK;
      ST_EU_CHK:  state_d = (r_q == '0) ? ST_K_MUL : ST_EU_DIV;
      ST_EU_DIV:  if (div_done) state_d = ST_EU_MUL;
      ST_EU_MUL:  state_d = ST_EU_UPD;
      ST_EU_UPD:  state_d = ST_EU_CHK;
      ST_K_MUL:   state_d = ST_K_DIV1;
      ST_K_DIV1:  if (div_done) state_d = ST_K_DIV2;
      ST_K_DIV2:  if (div_done) state_d = ST_K_DIV3;
      ST_K_DIV3:  if (div_done) state_d = ST_L_DIV;
      ST_L_DIV:   if (div_done) state_d = ST_L_MUL;
      ST_L_MUL:   state_d = ST_R_MUL;
      ST_R_MUL:   state_d = ST_R_DIV1;
      ST_R_DIV1:  if (div_done) state_d = ST_R_DIV2;
      ST_R_DIV2:  if (div_done) state_d = ST_R_FIX;
      ST_R_FIX:   state_d = stage_q ? ST_FIN1 : ST_EU_INIT;
      ST_FIN1:    state_d = ST_FIN2;
      ST_FIN2:    state_d = ST_OUT;
      ST_OUT:     if (result_o.ready) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // ---------------- unit operands and handshake outputs ----------------
  always_comb begin
    div_op    = 1'b0;
    div_a     = old_r_q;
    div_b     = AW'(r_q);
    mul_big   = quo_q;
    mul_small = s_q;
    item_i.ready   = 1'b0;
    result_o.valid = 1'b0;
    case (state_q)
      ST_IDLE:   item_i.ready = 1'b1;
      ST_EU_DIV: div_op = 1'b1;
      ST_K_MUL: begin
        mul_big   = AW'(res2_q) - r_cur_q;
        mul_small = old_s_q;
      end
      ST_K_DIV1: begin
        div_op = 1'b1;
        div_a  = prod_q;
        div_b  = AW'(old_r_q);
      end
      ST_K_DIV2: begin
        div_op = 1'b1;
        div_a  = AW'(mod2_q);
        div_b  = AW'(old_r_q);
      end
      ST_K_DIV3: begin
        div_op = 1'b1;
        div_a  = t1_q;
        div_b  = AW'(n_q);
      end
      ST_L_DIV: begin
        div_op = 1'b1;
        div_a  = m_cur_q;
        div_b  = AW'(old_r_q);
      end
      ST_L_MUL: mul_small = SW'(mod2_q);
      ST_R_MUL: begin
        mul_big   = m_cur_q;
        mul_small = k_q;
      end
      ST_R_DIV1: begin
        div_op = 1'b1;
        div_a  = prod_q;
        div_b  = AW'(lcm_q);
      end
      ST_R_DIV2: begin
        div_op = 1'b1;
        div_a  = x_q + r_cur_q;
        div_b  = AW'(lcm_q);
      end
      ST_OUT:  result_o.valid = 1'b1;
      default: ;
    endcase
  end

  assign result_o.days_until = $signed(out_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stage_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (item_xfer) begin
        stage_q <= 1'b0;
      end else if (state_q == ST_R_FIX) begin
        stage_q <= 1'b1;
      end
    end
  end

  // Final adjust works in a width that holds both the residue and the day.
  logic signed [FW-1:0] rc_w, day_w, lcm_w, diff_w;
  assign rc_w   = FW'(r_cur_q);
  assign lcm_w  = FW'(m_cur_q);
  assign day_w  = FW'(day_q);
  assign diff_w = rc_w - day_w;

  // ---------------- datapath ----------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        // Take the item and the moduli in force at this transfer.
        if (item_xfer) begin
          r_cur_q <= AW'(item_i.residue_first);
          m_cur_q <= AW'(eff_first);
          mod2_q  <= eff_second;
          res2_q  <= item_i.residue_second;
          mod3_q  <= eff_third;
          res3_q  <= item_i.residue_third;
          day_q   <= item_i.reference_day;
        end
      end
      ST_EU_INIT: begin
        old_r_q <= m_cur_q;
        r_q     <= AW'(mod2_q);
        old_s_q <= SW'(1);
        s_q     <= '0;
      end
      ST_EU_DIV: begin
        if (div_done) begin
          quo_q <= div_quo;
          rem_q <= div_rem;
        end
      end
      ST_EU_MUL: prod_q <= mul_p[AW-1:0];
      ST_EU_UPD: begin
        // Advance one Euclid step: (old, cur) <- (cur, old - q * cur).
        old_s_q <= s_q;
        s_q     <= old_s_q - $signed(prod_q[SW-1:0]);
        old_r_q <= r_q;
        r_q     <= rem_q;
      end
      ST_K_MUL:  prod_q <= mul_p[AW-1:0];
      ST_K_DIV1: if (div_done) t1_q <= div_quo;
      ST_K_DIV2: if (div_done) n_q <= div_quo;
      ST_K_DIV3: if (div_done) k_q <= div_rem[SW-1:0];
      ST_L_DIV:  if (div_done) quo_q <= div_quo;
      ST_L_MUL:  lcm_q <= mul_p[AW-1:0];
      ST_R_MUL:  prod_q <= mul_p[AW-1:0];
      ST_R_DIV1: if (div_done) x_q <= div_rem;
      ST_R_DIV2: if (div_done) x_q <= div_rem;
      ST_R_FIX: begin
        // Bring the merged residue into [0, lcm) and load the third congruence.
        r_cur_q <= x_q[AW-1] ? x_q + lcm_q : x_q;
        m_cur_q <= lcm_q;
        mod2_q  <= mod3_q;
        res2_q  <= res3_q;
      end
      ST_FIN1: if (rc_w <= day_w) r_cur_q <= AW'(rc_w + lcm_w);
      ST_FIN2: out_q <= diff_w[DAYS_W-1:0];
      default: ;
    endcase
  end

  // ---------------- assertions ----------------
  `CRT_ASSERT_NOW(a_ready_no_result, item_i.ready, !result_o.valid, "ready while result held")
  `CRT_ASSERT_NOW(a_done_pending, div_done, div_pend_q, "divider done without request")
  `CRT_ASSERT_NOW(a_div_nonzero, div_start, div_b != '0, "divide by zero issued")
  `CRT_ASSERT_NEXT(a_back_idle, res_xfer, item_i.ready, "not idle after result transfer")

endmodule
